@@ rtl/occurrence_capped_filter_macros.svh @@
// Assertion macros for the occurrence capped filter.
// Uses the i_clk and i_rst_n ports of the module that includes it.
`ifndef OCCURRENCE_CAPPED_FILTER_MACROS_SVH
`define OCCURRENCE_CAPPED_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OCF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/occ_pkg.sv @@
// Shared types and constants of the occurrence capped filter.
// No dependencies.
`default_nettype none
package occ_pkg;

    localparam int ENTRIES = 64;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [ENTRIES-1:0] t_entry_vec;

    typedef struct packed {
        logic keep;
        logic no_room;
        logic all_used;
        logic all_free;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/occ_table.sv @@
// Table of distinct values with occurrence counts, compared all at once.
// Depends on occ_pkg.
`default_nettype none
module occ_table (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_lookup,
    input  occ_pkg::t_value i_key,
    input  wire             i_last,
    input  occ_pkg::t_count i_max,
    output occ_pkg::t_status o_status
);
    import occ_pkg::*;

    t_value     r_seen_value [ENTRIES];
    t_count     r_seen_count [ENTRIES];
    t_entry_vec r_entry_valid;
    t_entry_vec n_entry_valid;

    t_entry_vec s_match;
    t_entry_vec s_below;
    t_entry_vec s_free;
    logic       s_hit;
    logic       s_max_nonzero;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            s_match[i] = r_entry_valid[i] && (r_seen_value[i] == i_key);
            s_below[i] = r_seen_count[i] < i_max;
        end
    end

    assign s_free        = ~r_entry_valid & (r_entry_valid + t_entry_vec'(1));
    assign s_hit         = |s_match;
    assign s_max_nonzero = |i_max;

    assign o_status.keep     = s_hit ? |(s_match & s_below) : s_max_nonzero;
    assign o_status.no_room  = !s_hit && !(|s_free);
    assign o_status.all_used = &r_entry_valid;
    assign o_status.all_free = !(|r_entry_valid);

    always_comb begin
        n_entry_valid = r_entry_valid;
        if (i_lookup) begin
            if (!s_hit) begin
                n_entry_valid = r_entry_valid | s_free;
            end
            if (i_last) begin
                n_entry_valid = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else begin
            r_entry_valid <= n_entry_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_lookup) begin
                if (s_match[i] && s_below[i]) begin
                    r_seen_count[i] <= r_seen_count[i] + t_count'(1);
                end else if (!s_hit && s_free[i]) begin
                    r_seen_value[i] <= i_key;
                    r_seen_count[i] <= t_count'(s_max_nonzero);
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/occurrence_capped_filter.sv @@
// Top level of the occurrence capped filter: input register, table, result register.
// Depends on occ_pkg, occ_table and occurrence_capped_filter_macros.svh.
//
// One word is accepted in every cycle, busy stays low, and each word's result passes
// the input and result registers to the strobe, high for one cycle; the receiver
// cannot stall. The rate is set by the combinational compare of the registered word
// against all 64 table entries, held in flip-flops, with the count update at the
// same edge. The table starts empty out of reset and needs no clearing pass.
`default_nettype none
module occurrence_capped_filter (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  occ_pkg::t_value i_value,
    input  wire             i_last,
    input  wire             i_cfg_valid,
    output logic            o_cfg_ready,
    input  occ_pkg::t_count i_cfg_max_occurrences,
    output logic            o_strobe,
    output occ_pkg::t_value o_value_out,
    output logic            o_keep,
    output logic            o_last_out,
    output logic            o_table_full
);
    import occ_pkg::*;

    `include "occurrence_capped_filter_macros.svh"

    logic    r_in_valid;
    t_value  r_value;
    logic    r_last;
    t_count  r_max;
    logic    r_strobe;
    t_value  r_value_out;
    logic    r_keep;
    logic    r_last_out;
    logic    r_full;
    t_status s_status;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_strobe   <= 1'b0;
            r_max      <= t_count'(1);
        end else begin
            r_in_valid <= start && !busy;
            r_strobe   <= r_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_max_occurrences;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_value <= i_value;
            r_last  <= i_last;
        end
        if (r_in_valid) begin
            r_value_out <= r_value;
            r_keep      <= s_status.keep;
            r_last_out  <= r_last;
            r_full      <= s_status.no_room;
        end
    end

    occ_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lookup (r_in_valid),
        .i_key    (r_value),
        .i_last   (r_last),
        .i_max    (r_max),
        .o_status (s_status)
    );

    assign o_strobe     = r_strobe;
    assign o_value_out  = r_value_out;
    assign o_keep       = r_keep;
    assign o_last_out   = r_last_out;
    assign o_table_full = r_full;

    `OCF_ASSERT_NEXT(a_result_follows, r_in_valid, o_strobe, "registered word gave no result")
    `OCF_ASSERT_SAME(a_full_stays_full, o_strobe && o_table_full && !o_last_out, s_status.all_used, "table_full reported while the table has room")
    `OCF_ASSERT_SAME(a_last_clears, o_strobe && o_last_out, s_status.all_free, "table not cleared after the last word of a list")

endmodule
`default_nettype wire

@@ tb/tb_occurrence_capped_filter.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for occurrence_capped_filter: directed and random lists of words,
// each judged against an in-bench occurrence table. Depends on occ_pkg and the RTL top level.
module tb_occurrence_capped_filter;
    import occ_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        t_value value;
        logic   keep;
        logic   last;
        logic   full;
    } t_verdict;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_value i_value = '0;
    logic   i_last = 1'b0;
    logic   i_cfg_valid = 1'b0;
    logic   o_cfg_ready;
    t_count i_cfg_max_occurrences = '0;
    logic   o_strobe;
    t_value o_value_out;
    logic   o_keep;
    logic   o_last_out;
    logic   o_table_full;

    t_value     tbl_value [ENTRIES];
    t_count     tbl_count [ENTRIES];
    t_entry_vec tbl_used = '0;
    t_count     occ_cap = 16'd1;

    t_verdict verdict_q[$];
    int       errors = 0;
    int       cycles = 0;

    occurrence_capped_filter u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_value               (i_value),
        .i_last                (i_last),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_max_occurrences (i_cfg_max_occurrences),
        .o_strobe              (o_strobe),
        .o_value_out           (o_value_out),
        .o_keep                (o_keep),
        .o_last_out            (o_last_out),
        .o_table_full          (o_table_full)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_verdict judge_value(t_value v, logic last);
        t_verdict r;
        int hit;
        int free_idx;
        hit = -1;
        free_idx = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_used[i]) begin
                if (hit < 0 && tbl_value[i] == v) hit = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        r.value = v;
        r.last = last;
        r.keep = 1'b0;
        r.full = 1'b0;
        if (hit >= 0) begin
            if (tbl_count[hit] < occ_cap) begin
                r.keep = 1'b1;
                tbl_count[hit] = tbl_count[hit] + 16'd1;
            end
        end else if (free_idx >= 0) begin
            r.keep = (occ_cap != 0);
            tbl_value[free_idx] = v;
            tbl_count[free_idx] = (occ_cap != 0) ? 16'd1 : 16'd0;
            tbl_used[free_idx] = 1'b1;
        end else begin
            r.full = 1'b1;
            r.keep = (occ_cap != 0);
        end
        if (last) tbl_used = '0;
        return r;
    endfunction

    always @(negedge i_clk) begin : result_check
        t_verdict exp_v;
        if (i_rst_n && o_strobe) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected word, actual value %h keep %b last %b full %b",
                         $realtime, o_value_out, o_keep, o_last_out, o_table_full);
                errors++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (o_value_out !== exp_v.value) begin
                    $display("%0t: value expected %h actual %h",
                             $realtime, exp_v.value, o_value_out);
                    errors++;
                end
                if (o_keep !== exp_v.keep) begin
                    $display("%0t: keep expected %b actual %b (value %h)",
                             $realtime, exp_v.keep, o_keep, exp_v.value);
                    errors++;
                end
                if (o_last_out !== exp_v.last) begin
                    $display("%0t: last expected %b actual %b (value %h)",
                             $realtime, exp_v.last, o_last_out, exp_v.value);
                    errors++;
                end
                if (o_table_full !== exp_v.full) begin
                    $display("%0t: table_full expected %b actual %b (value %h)",
                             $realtime, exp_v.full, o_table_full, exp_v.value);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(input t_value v, input logic last, input bit idle_on);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_value <= v;
        i_last <= last;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        verdict_q.push_back(judge_value(v, last));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_count cap);
        i_cfg_valid <= 1'b1;
        i_cfg_max_occurrences <= cap;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        occ_cap = cap;
    endtask

    function automatic t_value extreme_value();
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            default: return 32'shFFFF_FFFF;
        endcase
    endfunction

    // The reset maximum of one passes each value once per list.
    task automatic test_extremes;
        send_word(32'sh8000_0000, 1'b0, 1'b1);
        send_word(32'sh7FFF_FFFF, 1'b0, 1'b1);
        send_word(32'sh0000_0000, 1'b0, 1'b0);
        send_word(32'shFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'sh8000_0000, 1'b0, 1'b1);
        send_word(32'sh7FFF_FFFF, 1'b0, 1'b0);
        send_word(32'shFFFF_FFFF, 1'b1, 1'b1);
        send_word(32'sh8000_0000, 1'b1, 1'b0);
        send_word(32'sh8000_0000, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_repeat_cap;
        t_value a;
        t_value b;
        a = $urandom;
        b = ~a;
        cfg_write(16'd3);
        repeat (5) send_word(a, 1'b0, 1'b1);
        repeat (2) send_word(b, 1'b0, 1'b0);
        send_word(a, 1'b1, 1'b1);
        send_word(a, 1'b1, 1'b0);
        drain();
    endtask

    // Counts above a lowered maximum stay and their values are dropped.
    task automatic test_lowered_max;
        t_value a;
        t_value b;
        a = $urandom;
        b = a ^ 32'sh5555_5555;
        cfg_write(16'd4);
        repeat (4) send_word(a, 1'b0, 1'b1);
        drain();
        cfg_write(16'd2);
        send_word(a, 1'b0, 1'b1);
        repeat (3) send_word(b, 1'b0, 1'b0);
        send_word(a, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_zero_max;
        cfg_write(16'd0);
        send_word(32'sh1234_5678, 1'b0, 1'b1);
        send_word(32'sh1234_5678, 1'b0, 1'b0);
        send_word(32'sh8000_0000, 1'b1, 1'b1);
        drain();
        cfg_write(16'hFFFF);
        repeat (6) send_word(32'sh0000_0000, 1'b0, 1'b0);
        send_word(32'sh0000_0000, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_table_full;
        t_value base;
        base = $urandom;
        cfg_write(16'd2);
        for (int i = 0; i < ENTRIES; i++) send_word(base + i, 1'b0, i[0]);
        send_word(base - 1, 1'b0, 1'b1);
        send_word(base - 1, 1'b0, 1'b0);
        send_word(base, 1'b0, 1'b0);
        send_word(base, 1'b0, 1'b1);
        send_word(base - 2, 1'b1, 1'b0);
        send_word(base - 1, 1'b1, 1'b1);
        drain();
    endtask

    task automatic send_list(inout int sent);
        t_value pool [8];
        int     len;
        int     pool_n;
        bit     dense;
        bit     idle_on;
        t_value v;
        idle_on = ($urandom_range(0, 3) != 0);
        dense = ($urandom_range(0, 9) == 0);
        len = dense ? $urandom_range(66, 90) : $urandom_range(1, 20);
        pool_n = $urandom_range(1, 8);
        for (int k = 0; k < 8; k++) begin
            pool[k] = ($urandom_range(0, 3) == 0) ? extreme_value() : $urandom;
        end
        for (int i = 0; i < len; i++) begin
            if (dense || $urandom_range(0, 7) == 0) v = $urandom;
            else v = pool[$urandom_range(0, pool_n - 1)];
            send_word(v, i == len - 1, idle_on);
            sent++;
        end
    endtask

    task automatic test_random;
        t_count caps [6];
        int     sent;
        caps = '{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd0, 16'd0};
        for (int p = 0; p < 6; p++) begin
            cfg_write((p < 4) ? caps[p] : t_count'($urandom_range(1, 8)));
            sent = 0;
            while (sent < 145) send_list(sent);
            drain();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_repeat_cap();
        test_lowered_max();
        test_zero_max();
        test_table_full();
        test_random();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
